@@ rtl/mngq_pkg.sv @@
// Shared types and constants for the MIDI note grid quantizer.
// Used by the divider, the top level and the testbench; no dependencies.
package mngq_pkg;

   localparam int TPQ_W      = 15;   // width of both configuration registers
   localparam int STEP_W     = 15;   // grid step width
   localparam int KEY_N      = 128;  // number of MIDI keys
   localparam int KEY_W      = 7;
   localparam int VEL_W      = 7;
   localparam int STATUS_W   = 8;
   localparam int TICK_IN_W  = 28;   // request tick width
   localparam int TICK_W     = 29;   // response and onset tick width
   localparam int DVD_W      = 30;   // divider dividend and quotient width
   localparam int CNT_W      = 5;    // divider iteration counter width
   localparam int CSR_IDX_W  = 1;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 32;

   localparam logic [TPQ_W-1:0] TPQ_RESET = 15'd480;
   localparam logic [TPQ_W-1:0] DIV_RESET = 15'd8;

   localparam logic [CNT_W-1:0] STEP_ITERS = 5'd15;
   localparam logic [CNT_W-1:0] TICK_ITERS = 5'd30;

   localparam logic [CSR_IDX_W-1:0] REG_TPQ = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_DIV = 1'b1;

   localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;
   localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;

   localparam logic [1:0] KIND_OTHER   = 2'd0;
   localparam logic [1:0] KIND_ON      = 2'd1;
   localparam logic [1:0] KIND_MATCH   = 2'd2;
   localparam logic [1:0] KIND_UNMATCH = 2'd3;

   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] iters;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

@@ rtl/midi_note_grid_quantizer_top.sv @@
// Top level of the MIDI note grid quantizer: sequencer, key table and output register.
// Depends on mngq_pkg, mngq_div (shared divider) and mngq_ram (onset tick table).
//
//   Channel | Direction | Handshake          | Payload
//   req_    | in        | tvalid / tready    | tdata: event fields, tuser: first_of_track
//   rsp_    | out       | tvalid / tready    | tdata: new_tick, tuser: event_kind
//   csr_    | in        | valid / ready      | index, wdata (always ready)
//
// A note-on or a matched note-off goes through two passes of the shared radix-2 divider
// between request acceptance and response valid: 15 iterations to form the grid step
// and 30 iterations to round the tick or the note length.
// Other events and unmatched note-offs are answered in the cycle after acceptance.
// Reset clears all key active bits and loads 480 and 8 into the configuration registers;
// the onset table needs no clearing pass. A new request is taken only after the response
// of the previous one has been taken, so a stalled response stalls the request side.
module midi_note_grid_quantizer_top (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [7:0] status_byte, [14:8] key_number, [21:15] velocity, [49:22] event_tick,
   // [55:50] zero
   input  logic [mngq_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] first_of_track
   input  logic                                req_tuser,
   // Response channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [28:0] new_tick, [31:29] zero
   output logic [mngq_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [1:0] event_kind
   output logic [1:0]                          rsp_tuser,
   // Configuration write channel.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mngq_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mngq_pkg::TPQ_W-1:0]          csr_wdata
);
   import mngq_pkg::*;

   // Sequencer states.
   localparam logic [3:0] S_IDLE  = 4'd0;  // waiting for a request
   localparam logic [3:0] S_STEP  = 4'd1;  // start the grid step division
   localparam logic [3:0] S_STEPW = 4'd2;  // wait for the grid step
   localparam logic [3:0] S_VAL   = 4'd3;  // form the value to round
   localparam logic [3:0] S_DIV   = 4'd4;  // start the rounding division
   localparam logic [3:0] S_DIVW  = 4'd5;  // wait for the rounding quotient
   localparam logic [3:0] S_MUL   = 4'd6;  // quotient times step
   localparam logic [3:0] S_FIN   = 4'd7;  // final tick, table update
   localparam logic [3:0] S_OUT   = 4'd8;  // response presented

   logic [3:0]         state_ff, state_in;
   logic [TPQ_W-1:0]   tpq_ff, tpq_in;
   logic [TPQ_W-1:0]   div_ff, div_in;
   logic [KEY_N-1:0]   key_active_ff, key_active_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [TICK_IN_W-1:0] tick_ff, tick_in;
   logic [1:0]         kind_ff, kind_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic signed [30:0] val_ff, val_in;
   logic [DVD_W-1:0]   prod_ff, prod_in;
   logic [TICK_W-1:0]  new_tick_ff, new_tick_in;

   // Request fields.
   logic [3:0]           req_hi;
   logic [KEY_W-1:0]     req_key;
   logic [VEL_W-1:0]     req_vel;
   logic [TICK_IN_W-1:0] req_tick;
   logic                 req_accept;
   logic                 active_now;
   logic                 is_on;
   logic                 is_off;

   // Datapath.
   div_ctl_type         div_ctl;
   div_sts_type         div_sts;
   logic [DVD_W-1:0]    div_dividend;
   logic [STEP_W-1:0]   div_divisor;
   logic [DVD_W-1:0]    div_quotient;
   logic [TICK_W-1:0]   onset;
   logic [30:0]         val_abs;
   logic [DVD_W+STEP_W-1:0] prod_full;
   logic signed [31:0]  fin_base;
   logic signed [31:0]  fin_delta;
   logic signed [31:0]  fin_sum;
   logic [TICK_W-1:0]   fin_tick;
   logic                ram_wr_en;

   assign req_hi     = req_tdata[7:4];
   assign req_key    = req_tdata[14:8];
   assign req_vel    = req_tdata[21:15];
   assign req_tick   = req_tdata[49:22];
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // A first-of-track event sees an empty key table.
   assign active_now = key_active_ff[req_key] && !req_tuser;
   assign is_on      = (req_hi == STATUS_NOTE_ON) && (req_vel != '0);
   assign is_off     = (req_hi == STATUS_NOTE_OFF) || (req_hi == STATUS_NOTE_ON);

   // The divider is shared: first ticks_per_quarter / grid_division, left-aligned so that
   // 15 iterations suffice, then the magnitude of the value to round divided by the step.
   // The divisor is read on every iteration, so its source register stays selected for the whole pass.
   assign div_ctl.start = (state_ff == S_STEP) || (state_ff == S_DIV);
   assign div_ctl.iters = (state_ff == S_STEP) ? STEP_ITERS : TICK_ITERS;
   assign val_abs       = val_ff[30] ? (~val_ff + 31'd1) : val_ff;
   assign div_dividend  = (state_ff == S_STEP) ? {tpq_ff, {STEP_W{1'b0}}} : val_abs[DVD_W-1:0];
   assign div_divisor   = ((state_ff == S_STEP) || (state_ff == S_STEPW)) ? div_ff : step_ff;

   mngq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .sts      (div_sts),
      .quotient (div_quotient)
   );

   // Onset table: read address is the latched key for the whole item, so the read data
   // is settled long before it is used. It is written only for a note-on.
   assign ram_wr_en = (state_ff == S_FIN) && (kind_ff == KIND_ON);

   mngq_ram #(
      .WIDTH (TICK_W),
      .DEPTH (KEY_N)
   ) u_onset_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (key_ff),
      .wr_data (fin_tick),
      .rd_addr (key_ff),
      .rd_data (onset)
   );

   // The quotient magnitude times the step never exceeds the rounded magnitude, so the
   // low bits of the product are exact.
   assign prod_full = div_quotient * step_ff;

   // Final tick: the onset (for a note-off) plus the signed rounded value. The quotient
   // truncates toward zero because the magnitude was divided and the sign put back here.
   // A tick below zero is clamped to zero.
   assign fin_base  = (kind_ff == KIND_ON) ? 32'sd0 : $signed({3'b000, onset});
   assign fin_delta = val_ff[30] ? -$signed({2'b00, prod_ff}) : $signed({2'b00, prod_ff});
   assign fin_sum   = fin_base + fin_delta;
   assign fin_tick  = fin_sum[31] ? '0 : fin_sum[TICK_W-1:0];

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_comb begin
      tpq_in = tpq_ff;
      div_in = div_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_TPQ: tpq_in = csr_wdata;
            REG_DIV: div_in = csr_wdata;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      key_active_in = key_active_ff;
      key_in        = key_ff;
      tick_in       = tick_ff;
      kind_in       = kind_ff;
      step_in       = step_ff;
      val_in        = val_ff;
      prod_in       = prod_ff;
      new_tick_in   = new_tick_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               key_in  = req_key;
               tick_in = req_tick;
               if (req_tuser) begin
                  key_active_in = '0;
               end
               if (is_on) begin
                  kind_in  = KIND_ON;
                  state_in = S_STEP;
               end else if (is_off && active_now) begin
                  kind_in  = KIND_MATCH;
                  state_in = S_STEP;
               end else begin
                  // Unmatched note-offs and other events keep their tick.
                  kind_in     = is_off ? KIND_UNMATCH : KIND_OTHER;
                  new_tick_in = {1'b0, req_tick};
                  state_in    = S_OUT;
               end
            end
         end
         S_STEP: begin
            state_in = S_STEPW;
         end
         S_STEPW: begin
            if (div_sts.done) begin
               // A zero divisor or a zero quotient gives a step of one.
               if ((div_ff == '0) || (div_quotient[STEP_W-1:0] == '0)) begin
                  step_in = STEP_W'(1);
               end else begin
                  step_in = div_quotient[STEP_W-1:0];
               end
               state_in = S_VAL;
            end
         end
         S_VAL: begin
            // Note-on rounds the tick; note-off rounds the length from the onset.
            if (kind_ff == KIND_ON) begin
               val_in = $signed({3'b000, tick_ff}) + $signed({17'd0, step_ff[STEP_W-1:1]});
            end else begin
               val_in = $signed({3'b000, tick_ff}) - $signed({2'b00, onset})
                      + $signed({17'd0, step_ff[STEP_W-1:1]});
            end
            state_in = S_DIV;
         end
         S_DIV: begin
            state_in = S_DIVW;
         end
         S_DIVW: begin
            if (div_sts.done) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = prod_full[DVD_W-1:0];
            state_in = S_FIN;
         end
         S_FIN: begin
            new_tick_in            = fin_tick;
            key_active_in[key_ff]  = (kind_ff == KIND_ON);
            state_in               = S_OUT;
         end
         S_OUT: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         key_active_ff <= '0;
         tpq_ff        <= TPQ_RESET;
         div_ff        <= DIV_RESET;
      end else begin
         state_ff      <= state_in;
         key_active_ff <= key_active_in;
         tpq_ff        <= tpq_in;
         div_ff        <= div_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      tick_ff     <= tick_in;
      kind_ff     <= kind_in;
      step_ff     <= step_in;
      val_ff      <= val_in;
      prod_ff     <= prod_in;
      new_tick_ff <= new_tick_in;
   end

   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {{(RSP_DATA_W-TICK_W){1'b0}}, new_tick_ff};
   assign rsp_tuser  = kind_ff;

`ifndef SYNTH
   // The block holds one item at a time: never ready for a request while a response waits.
   a_one_item : assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while a response is pending");

   // The shared divider is quiet whenever the sequencer is idle.
   a_div_quiet : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !div_sts.busy)
      else $error("divider busy while sequencer idle");

   // Events that are not quantized leave with their original tick.
   a_pass_tick : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && ((rsp_tuser == KIND_OTHER) || (rsp_tuser == KIND_UNMATCH)))
      |-> (rsp_tdata[TICK_W-1:0] == {1'b0, tick_ff}))
      else $error("pass-through event changed its tick");

   // A first-of-track request empties the key table.
   a_track_clear : assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tuser) |=> (key_active_ff == '0))
      else $error("key table not cleared at start of track");
`endif

endmodule

@@ rtl/mngq_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module mngq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/mngq_div.sv @@
// Shared radix-2 restoring divider, one quotient bit per cycle.
// Depends on mngq_pkg for widths and the control and status structs.
module mngq_div (
   input  logic                             clock,
   input  logic                             reset,
   input  mngq_pkg::div_ctl_type            ctl,
   input  logic [mngq_pkg::DVD_W-1:0]       dividend,
   input  logic [mngq_pkg::STEP_W-1:0]      divisor,
   output mngq_pkg::div_sts_type            sts,
   output logic [mngq_pkg::DVD_W-1:0]       quotient
);
   import mngq_pkg::*;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [STEP_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [DVD_W-1:0]  quo_ff, quo_in;

   logic [STEP_W:0]   shifted;
   logic [STEP_W+1:0] diff;
   logic              fits;

   // Bring down the next dividend bit and try to subtract the divisor.
   assign shifted = {rem_ff, dvd_ff[DVD_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, divisor};
   assign fits    = !diff[STEP_W+1];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = ctl.iters;
         rem_in  = '0;
         dvd_in  = dividend;
         quo_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         rem_in = fits ? diff[STEP_W-1:0] : shifted[STEP_W-1:0];
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         quo_in = {quo_ff[DVD_W-2:0], fits};
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quotient = quo_ff;

endmodule

@@ bench/midi_note_grid_quantizer_top_tb.sv @@
// Self-checking testbench for midi_note_grid_quantizer_top: a directed table of MIDI events,
// then phases of random note traffic under changing grid settings, all checked in order.
// Depends on mngq_pkg and the quantizer RTL; needs no files or arguments.
module midi_note_grid_quantizer_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mngq_pkg::*;

   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int DRAIN_CYCLES = 60;     // longer than a quantized note takes from request to response
   localparam int NVEC         = 17;
   localparam int NPHASE       = 10;
   localparam int PHASE_ITEMS  = 170;
   localparam longint TICK_MAX = 64'h0FFFFFFF;

   typedef struct {
      logic                 first_trk;
      logic [STATUS_W-1:0]  status;
      logic [KEY_W-1:0]     note_key;
      logic [VEL_W-1:0]     vel;
      logic [TICK_IN_W-1:0] tick;
   } midi_ev_type;

   typedef struct {
      logic [TICK_W-1:0] tick;
      logic [1:0]        kind;
   } quant_res_type;

   // One row of the directed table. Where typed is set, the expected response is written
   // out here; otherwise it comes from the quantizer model below.
   typedef struct {
      logic                 first_trk;
      logic [STATUS_W-1:0]  status;
      logic [KEY_W-1:0]     note_key;
      logic [VEL_W-1:0]     vel;
      logic [TICK_IN_W-1:0] tick;
      bit                   typed;
      logic [TICK_W-1:0]    exp_tick;
      logic [1:0]           exp_kind;
   } vector_row_type;

   // All rows run under the reset settings: 480 / 8 gives a 60-tick grid.
   vector_row_type vectors [NVEC] = '{
      // Note-on at tick zero with the track flag set, then its note-off.
      '{1'b1, {STATUS_NOTE_ON, 4'h0},  7'd60,  7'd100, 28'd0,   1'b1, 29'd0,   KIND_ON},
      '{1'b0, {STATUS_NOTE_OFF, 4'h0}, 7'd60,  7'd0,   28'd100, 1'b1, 29'd120, KIND_MATCH},
      // The key is free again, so a second note-off passes unchanged.
      '{1'b0, {STATUS_NOTE_OFF, 4'h0}, 7'd60,  7'd0,   28'd500, 1'b1, 29'd500, KIND_UNMATCH},
      '{1'b0, 8'hF0, 7'd0, 7'd0, 28'hFFFFFFF, 1'b1, 29'h0FFFFFFF, KIND_OTHER},
      // Largest tick on the top key, then a zero-velocity note-on at tick zero that
      // ends the note long before it began.
      '{1'b0, {STATUS_NOTE_ON, 4'hF},  7'd127, 7'd127, 28'hFFFFFFF, 1'b0, 29'd0, KIND_OTHER},
      '{1'b0, {STATUS_NOTE_ON, 4'hF},  7'd127, 7'd0,   28'd0,       1'b0, 29'd0, KIND_OTHER},
      // Just below and exactly at the half-step boundary; the second note-on lands on an
      // active key and replaces its onset.
      '{1'b0, {STATUS_NOTE_ON, 4'h5},  7'd0,   7'd1,   28'd29,  1'b1, 29'd0,   KIND_ON},
      '{1'b0, {STATUS_NOTE_ON, 4'h5},  7'd0,   7'd1,   28'd30,  1'b1, 29'd60,  KIND_ON},
      '{1'b0, {STATUS_NOTE_OFF, 4'h5}, 7'd0,   7'd127, 28'd89,  1'b0, 29'd0,   KIND_OTHER},
      // A new track frees the held key before its note-off is handled.
      '{1'b0, {STATUS_NOTE_ON, 4'h3},  7'd5,   7'd64,  28'd1000, 1'b0, 29'd0,   KIND_OTHER},
      '{1'b1, {STATUS_NOTE_OFF, 4'h3}, 7'd5,   7'd64,  28'd2000, 1'b1, 29'd2000, KIND_UNMATCH},
      // Other events, whatever their data bytes.
      '{1'b0, 8'h00, 7'd127, 7'd127, 28'h5555555, 1'b1, 29'h05555555, KIND_OTHER},
      '{1'b0, 8'hAA, 7'd85,  7'd42,  28'hAAAAAAA, 1'b1, 29'h0AAAAAAA, KIND_OTHER},
      '{1'b0, 8'h7F, 7'd0,   7'd0,   28'd0,       1'b1, 29'd0,        KIND_OTHER},
      // Note ended by a zero-velocity note-on slightly before its rounded onset.
      '{1'b0, {STATUS_NOTE_ON, 4'h0},  7'd64,  7'd127, 28'd1000, 1'b0, 29'd0, KIND_OTHER},
      '{1'b0, {STATUS_NOTE_ON, 4'h0},  7'd64,  7'd0,   28'd990,  1'b0, 29'd0, KIND_OTHER},
      '{1'b0, {STATUS_NOTE_ON, 4'h9},  7'd100, 7'd0,   28'd7,    1'b1, 29'd7, KIND_UNMATCH}
   };

   logic                      clock;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_W-1:0]     req_tdata  = '0;
   logic                      req_tuser  = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]     rsp_tdata;
   logic [1:0]                rsp_tuser;
   logic                      csr_valid  = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index  = '0;
   logic [TPQ_W-1:0]          csr_wdata  = '0;

   // Model state: settings, onset table and held keys.
   logic [TPQ_W-1:0]     cfg_tpq = TPQ_RESET;
   logic [TPQ_W-1:0]     cfg_div = DIV_RESET;
   logic [TICK_W-1:0]    onset_tab [KEY_N];
   bit                   key_on [KEY_N];
   bit [TICK_IN_W-1:0]   raw_onset [KEY_N];   // unrounded note-on tick, for note lengths
   longint               song_pos = 0;

   quant_res_type        expected_q [$];
   int                   errors    = 0;
   int                   cycle_cnt = 0;
   bit                   quiet     = 1'b0;    // no idling on either side when set
   int                   stall_left = 0;

   midi_note_grid_quantizer_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint grid_step();
      longint q;
      if (cfg_div == 0) return 1;
      q = cfg_tpq / cfg_div;
      return (q == 0) ? 1 : q;
   endfunction

   // Round half up on the grid; the quotient truncates toward zero, as it must for
   // negative note lengths.
   function automatic longint snap(input longint v, input longint s);
      return ((v + s / 2) / s) * s;
   endfunction

   function automatic void quantize(input midi_ev_type ev, output quant_res_type res);
      longint     s;
      longint     t;
      longint     onset;
      logic [3:0] hi;
      s  = grid_step();
      hi = ev.status[7:4];
      if (ev.first_trk) foreach (key_on[i]) key_on[i] = 1'b0;
      res.tick = TICK_W'(ev.tick);
      res.kind = KIND_OTHER;
      if (hi == STATUS_NOTE_ON && ev.vel != 0) begin
         t = snap(longint'(ev.tick), s);
         onset_tab[ev.note_key] = t[TICK_W-1:0];
         key_on[ev.note_key]    = 1'b1;
         res.tick = t[TICK_W-1:0];
         res.kind = KIND_ON;
      end else if (hi == STATUS_NOTE_OFF || hi == STATUS_NOTE_ON) begin
         if (key_on[ev.note_key]) begin
            onset = longint'(onset_tab[ev.note_key]);
            t = onset + snap(longint'(ev.tick) - onset, s);
            if (t < 0) t = 0;
            key_on[ev.note_key] = 1'b0;
            res.tick = t[TICK_W-1:0];
            res.kind = KIND_MATCH;
         end else begin
            res.kind = KIND_UNMATCH;
         end
      end
   endfunction

   // Offer one request, after an optional idle burst, and record what it must produce
   // once the block takes it. Called just after the clock rises.
   task automatic send_event(input midi_ev_type ev, input bit typed,
                             input quant_res_type fixed);
      quant_res_type res;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= ev.first_trk;
      req_tdata  <= {6'd0, ev.tick, ev.vel, ev.note_key, ev.status};
      do @(posedge clock); while (!(req_tvalid && req_tready));
      quantize(ev, res);
      expected_q.push_back(typed ? fixed : res);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [TPQ_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      if (idx == REG_TPQ) cfg_tpq = val;
      else cfg_div = val;
   endtask

   // Let every outstanding response come back, then give the block time to go idle.
   task automatic settle();
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Random traffic is mostly note-on / note-off pairs on held keys with random lengths,
   // including some that end before they start; the rest is stray note-offs, other events
   // and the occasional new track.
   task automatic make_event(output midi_ev_type ev);
      int     pick;
      int     start;
      int     k;
      longint s;
      longint t;
      s = grid_step();
      song_pos = (song_pos + $urandom_range(0, 3 * s)) & TICK_MAX;
      ev.first_trk = ($urandom_range(0, 39) == 0);
      ev.note_key  = KEY_W'($urandom_range(0, 127));
      ev.vel       = VEL_W'($urandom_range(0, 127));
      ev.tick      = ($urandom_range(0, 7) == 0) ? TICK_IN_W'($urandom_range(0, TICK_MAX))
                                                  : song_pos[TICK_IN_W-1:0];
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         ev.status = {STATUS_NOTE_ON, 4'($urandom_range(0, 15))};
         ev.vel    = VEL_W'($urandom_range(1, 127));
         raw_onset[ev.note_key] = ev.tick;
      end else begin
         if ($urandom_range(0, 1) == 0) begin
            ev.status = {STATUS_NOTE_OFF, 4'($urandom_range(0, 15))};
         end else begin
            ev.status = {STATUS_NOTE_ON, 4'($urandom_range(0, 15))};
            ev.vel    = '0;
         end
         if (pick < 85) begin
            start = $urandom_range(0, 127);
            k = -1;
            for (int i = 0; i < KEY_N; i++)
               if (k < 0 && key_on[(start + i) % KEY_N]) k = (start + i) % KEY_N;
            if (k < 0) k = start;
            ev.note_key = KEY_W'(k);
            t = raw_onset[k];
            if ($urandom_range(0, 7) == 0) t = t - $urandom_range(0, 4 * s);
            else t = t + $urandom_range(0, 8 * s);
            if (t < 0) t = 0;
            if (t > TICK_MAX) t = TICK_MAX;
            ev.tick = t[TICK_IN_W-1:0];
         end else if (pick >= 95) begin
            do ev.status = STATUS_W'($urandom_range(0, 255));
            while (ev.status[7:4] == STATUS_NOTE_OFF || ev.status[7:4] == STATUS_NOTE_ON);
         end
      end
   endtask

   // Response side: random back-pressure bursts and in-order checking.
   always @(posedge clock) begin : rsp_side
      quant_res_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               $error("response with no request outstanding: new_tick %0d, event_kind %0d",
                      rsp_tdata[TICK_W-1:0], rsp_tuser);
               errors++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_tdata[TICK_W-1:0] !== want.tick) begin
                  $error("new_tick: expected %0d, got %0d", want.tick,
                         rsp_tdata[TICK_W-1:0]);
                  errors++;
               end
               if (rsp_tuser !== want.kind) begin
                  $error("event_kind: expected %0d, got %0d", want.kind, rsp_tuser);
                  errors++;
               end
            end
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 4);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt >= LIMIT_CYCLES) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      midi_ev_type      ev;
      quant_res_type    fixed;
      logic [TPQ_W-1:0] tpq;
      logic [TPQ_W-1:0] div;
      foreach (key_on[i]) key_on[i] = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed table under the reset settings.
      for (int i = 0; i < NVEC; i++) begin
         ev = '{vectors[i].first_trk, vectors[i].status, vectors[i].note_key,
                vectors[i].vel, vectors[i].tick};
         fixed.tick = vectors[i].exp_tick;
         fixed.kind = vectors[i].exp_kind;
         send_event(ev, vectors[i].typed, fixed);
      end
      req_tvalid <= 1'b0;

      // Random phases. The first ones pin the extremes of both registers; keys held
      // across a change of settings end on the new grid.
      for (int ph = 0; ph < NPHASE; ph++) begin
         settle();
         case (ph)
            0: begin
               tpq = 15'd1;        // quotient is zero, so the step falls back to one
               div = 15'd32767;
            end
            1: begin
               tpq = 15'd32767;    // widest possible step
               div = 15'd1;
            end
            2: begin
               tpq = 15'd32767;
               div = 15'd32767;
            end
            3: begin
               tpq = TPQ_RESET;
               div = DIV_RESET;
            end
            default: begin
               tpq = ($urandom_range(0, 3) == 0) ? TPQ_W'($urandom_range(1, 32767))
                                                 : TPQ_W'($urandom_range(24, 960));
               div = ($urandom_range(0, 3) == 0) ? TPQ_W'($urandom_range(1, 32767))
                                                 : TPQ_W'($urandom_range(1, 16));
            end
         endcase
         if ($urandom_range(0, 1) == 0) begin
            write_csr(REG_TPQ, tpq);
            write_csr(REG_DIV, div);
         end else begin
            write_csr(REG_DIV, div);
            write_csr(REG_TPQ, tpq);
         end
         quiet = (ph == NPHASE - 1);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            make_event(ev);
            send_event(ev, 1'b0, fixed);
         end
         req_tvalid <= 1'b0;
      end

      settle();
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ files.f @@
rtl/mngq_pkg.sv
rtl/mngq_ram.sv
rtl/mngq_div.sv
rtl/midi_note_grid_quantizer_top.sv
bench/midi_note_grid_quantizer_top_tb.sv
